>>> rtl/core/gma_pkg.sv
// Shared constants, register codes and control types for the gated moving average.
package gma_pkg;

	localparam int WINDOW    = 8;
	localparam int LEVEL_W   = 8;
	localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W     = $clog2(WINDOW + 1);
	localparam int SUM_W     = LEVEL_W + CNT_W;
	localparam int DCNT_W    = $clog2(SUM_W + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = LEVEL_W'(210);
	localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = LEVEL_W'(0);

	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = CFG_IDX_W'(1);

	typedef struct packed {
		logic load_in;
		logic update;
		logic div_step;
		logic avg_load;
		logic out_load;
	} gma_cmd_t;

	typedef struct packed {
		logic ok;
		logic div_done;
	} gma_stat_t;

endpackage

>>> rtl/core/gated_moving_average.sv
// Top level of the gated moving average filter.
// Each request carries one 8-bit sample and yields one result: the truncated
// average of the samples held in an 8-entry ring window, whether this sample
// fell inside [min_level, max_level] and entered the window, and whether the
// window is full. A rejected sample changes nothing and repeats the held
// average. An accepted request runs through load, window update, 12 steps
// of the bit-serial divider by the fill count, quotient load and result
// load; a rejected one runs through load, range decision and result load.
// The result sits in an output register, so the next request is taken while
// the previous result still waits. Registers: index 0 is max_level (reset
// 210), index 1 is min_level (reset 0); write them only while the block is idle.
module gated_moving_average (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [gma_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gma_pkg::LEVEL_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [gma_pkg::LEVEL_W-1:0]   sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gma_pkg::LEVEL_W-1:0]   average,
	output logic                          accepted,
	output logic                          data_ready
);
	import gma_pkg::*;

	gma_cmd_t  cmd;
	gma_stat_t stat;

	gma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	gma_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (sample),
		.cmd        (cmd),
		.stat       (stat),
		.average    (average),
		.accepted   (accepted),
		.data_ready (data_ready)
	);

endmodule

>>> rtl/core/gma_ctrl.sv
// Controller state machine for the gated moving average.
module gma_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  gma_pkg::gma_stat_t stat,
	output gma_pkg::gma_cmd_t  cmd
);
	import gma_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_UPDATE = 4'b0010,
		S_DIVIDE = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_UPDATE;
				end
			end
			S_UPDATE: begin
				if (stat.ok) begin
					cmd.update = 1'b1;
					state_d    = S_DIVIDE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIVIDE: begin
				if (stat.div_done) begin
					cmd.avg_load = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/gma_datapath.sv
// Datapath: range gate, ring window, running sum, serial divider and result register.
module gma_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [gma_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gma_pkg::LEVEL_W-1:0]       cfg_data,
	input  logic [gma_pkg::LEVEL_W-1:0]       sample,
	input  gma_pkg::gma_cmd_t                 cmd,
	output gma_pkg::gma_stat_t                stat,
	output logic [gma_pkg::LEVEL_W-1:0]       average,
	output logic                              accepted,
	output logic                              data_ready
);
	import gma_pkg::*;

	logic [LEVEL_W-1:0] max_q, min_q;
	logic [LEVEL_W-1:0] sample_q;
	logic               ok_q;
	logic [LEVEL_W-1:0] window_q [WINDOW];
	logic [SUM_W-1:0]   sum_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [CNT_W-1:0]   fill_q;
	logic [LEVEL_W-1:0] avg_q;
	logic [CNT_W-1:0]   div_rem_q;
	logic [SUM_W-1:0]   div_quo_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic [LEVEL_W-1:0] average_q;
	logic               accepted_q;
	logic               data_ready_q;

	logic [SUM_W-1:0]   sum_next;
	logic [CNT_W:0]     trial;
	logic               trial_ge;
	logic [CNT_W:0]     trial_diff;
	logic               full;

	assign full     = (fill_q == CNT_W'(WINDOW));
	assign sum_next = sum_q + SUM_W'(sample_q) - SUM_W'(window_q[ptr_q]);

	assign trial      = {div_rem_q, div_quo_q[SUM_W-1]};
	assign trial_ge   = (trial >= {1'b0, fill_q});
	assign trial_diff = trial - {1'b0, fill_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_LEVEL_RST;
			min_q <= MIN_LEVEL_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_MAX_LEVEL: max_q <= cfg_data;
				REG_MIN_LEVEL: min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q <= sample;
			ok_q     <= (sample <= max_q) && (sample >= min_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				window_q[i] <= '0;
			end
			sum_q  <= '0;
			ptr_q  <= '0;
			fill_q <= '0;
			avg_q  <= '0;
		end else begin
			if (cmd.update) begin
				window_q[ptr_q] <= sample_q;
				sum_q           <= sum_next;
				ptr_q           <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.avg_load) begin
				avg_q <= div_quo_q[LEVEL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.update) begin
			div_cnt_q <= DCNT_W'(SUM_W);
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			div_rem_q <= '0;
			div_quo_q <= sum_next;
		end else if (cmd.div_step) begin
			div_rem_q <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
			div_quo_q <= {div_quo_q[SUM_W-2:0], trial_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			average_q    <= '0;
			accepted_q   <= 1'b0;
			data_ready_q <= 1'b0;
		end else if (cmd.out_load) begin
			average_q    <= avg_q;
			accepted_q   <= ok_q;
			data_ready_q <= full;
		end
	end

	assign stat.ok       = ok_q;
	assign stat.div_done = (div_cnt_q == '0);
	assign average       = average_q;
	assign accepted      = accepted_q;
	assign data_ready    = data_ready_q;

endmodule

>>> rtl/core/gma_checker.sv
// Port-level checker for the gated moving average, bound to the top level.
module gma_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [gma_pkg::LEVEL_W-1:0]   average,
	input logic                          data_ready
);
	import gma_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(average) && $stable(data_ready))
		else $error("stalled result changed");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while first is in progress");

	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(data_ready))
		else $error("window full flag dropped");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result shown without request in progress");

endmodule

bind gated_moving_average gma_checker u_gma_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.average    (average),
	.data_ready (data_ready)
);
